// ----- rtl/aavr_pkg.sv -----
// shared types and constants for the axis-angle vector rotation unit
// no dependencies
package aavr_pkg;

  localparam int AXIS_W    = 16;
  localparam int AXIS_FRAC = 14;
  localparam int TAB_LEN   = 24;
  localparam int CS_W      = 34;
  localparam int Z_W       = 33;
  localparam int BN_W      = 36;
  localparam int M_W       = 39;
  localparam int MAT_W     = 32;
  localparam int MAT_DROP  = 6;
  localparam int MAT_FRAC  = 24;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic signed [CS_W-1:0]   cs_t;
  typedef logic signed [Z_W-1:0]    zang_t;
  typedef logic signed [BN_W-1:0]   bn_t;
  typedef logic signed [M_W-1:0]    m_t;
  typedef logic signed [MAT_W-1:0]  mat_t;

  localparam cs_t GAIN_Q30  = 34'sd652032874;
  localparam cs_t ONE_Q30   = 34'sd1073741824;
  localparam mat_t MAT_HI   = 32'sd1073741824;
  localparam mat_t MAT_LO   = -32'sd1073741824;

  localparam logic [31:0] ATAN_TURNS [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

// ----- rtl/aavr_in_if.sv -----
// input word channel: vector, axis and angle with valid/ready
// uses aavr_pkg
interface aavr_in_if #(parameter int VEC_WIDTH = 18, parameter int ANGLE_BITS = 16);
  logic                        valid;
  logic                        ready;
  logic signed [VEC_WIDTH-1:0] vec_x;
  logic signed [VEC_WIDTH-1:0] vec_y;
  logic signed [VEC_WIDTH-1:0] vec_z;
  aavr_pkg::axis_t             axis_x;
  aavr_pkg::axis_t             axis_y;
  aavr_pkg::axis_t             axis_z;
  logic [ANGLE_BITS-1:0]       angle;
  modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
                  input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
                  output ready);
endinterface

// ----- rtl/aavr_out_if.sv -----
// result word channel: rotated vector with valid/ready
// no dependencies
interface aavr_out_if #(parameter int VEC_WIDTH = 18);
  logic                        valid;
  logic                        ready;
  logic signed [VEC_WIDTH-1:0] rot_x;
  logic signed [VEC_WIDTH-1:0] rot_y;
  logic signed [VEC_WIDTH-1:0] rot_z;
  modport source (output valid, rot_x, rot_y, rot_z, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

// ----- rtl/aavr_cordic.sv -----
// pipelined cordic giving cos and sin of a binary angle, one stage per iteration
// carries vector and axis alongside; uses aavr_pkg
module aavr_cordic #(
  parameter int VEC_WIDTH     = 18,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        feed_valid,
  output logic                        feed_ready,
  input  logic [ANGLE_BITS-1:0]       angle,
  input  logic signed [VEC_WIDTH-1:0] vec_in [3],
  input  aavr_pkg::axis_t             axis_in [3],
  output logic                        res_valid,
  input  logic                        res_ready,
  output aavr_pkg::cs_t               cos_q,
  output aavr_pkg::cs_t               sin_q,
  output logic signed [VEC_WIDTH-1:0] vec_out [3],
  output aavr_pkg::axis_t             axis_out [3]
);

  localparam int N = CORDIC_STAGES + 2;

  logic [N-1:0] vld;
  logic [N:0]   adv;

  aavr_pkg::cs_t               x [CORDIC_STAGES+1];
  aavr_pkg::cs_t               y [CORDIC_STAGES+1];
  aavr_pkg::zang_t             z [CORDIC_STAGES+1];
  logic [1:0]                  q [CORDIC_STAGES+1];
  logic signed [VEC_WIDTH-1:0] vp [CORDIC_STAGES+1][3];
  aavr_pkg::axis_t             ap [CORDIC_STAGES+1][3];

  logic [31:0] a_full;
  logic [31:0] a_bias;
  logic [1:0]  q_in;
  logic [31:0] d_in;

  always_comb begin
    adv[N] = res_ready;
    for (int k = N - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign feed_ready = adv[0];
  assign res_valid  = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= feed_valid;
      end
      for (int k = 1; k < N; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // quadrant pick and residual angle
  always_comb begin
    a_full = {angle, {(32 - ANGLE_BITS){1'b0}}};
    a_bias = a_full + 32'h2000_0000;
    q_in   = a_bias[31:30];
    d_in   = a_full - {q_in, 30'd0};
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x[0]  <= aavr_pkg::GAIN_Q30;
      y[0]  <= '0;
      z[0]  <= aavr_pkg::zang_t'($signed(d_in));
      q[0]  <= q_in;
      vp[0] <= vec_in;
      ap[0] <= axis_in;
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (adv[k+1]) begin
        if (!z[k][aavr_pkg::Z_W-1]) begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - $signed({1'b0, aavr_pkg::ATAN_TURNS[k]});
        end else begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + $signed({1'b0, aavr_pkg::ATAN_TURNS[k]});
        end
        q[k+1]  <= q[k];
        vp[k+1] <= vp[k];
        ap[k+1] <= ap[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[N-1]) begin
      unique case (q[CORDIC_STAGES])
        aavr_pkg::QUAD_0: begin
          cos_q <= x[CORDIC_STAGES];
          sin_q <= y[CORDIC_STAGES];
        end
        aavr_pkg::QUAD_1: begin
          cos_q <= -y[CORDIC_STAGES];
          sin_q <= x[CORDIC_STAGES];
        end
        aavr_pkg::QUAD_2: begin
          cos_q <= -x[CORDIC_STAGES];
          sin_q <= -y[CORDIC_STAGES];
        end
        default: begin
          cos_q <= y[CORDIC_STAGES];
          sin_q <= -x[CORDIC_STAGES];
        end
      endcase
      vec_out  <= vp[CORDIC_STAGES];
      axis_out <= ap[CORDIC_STAGES];
    end
  end

endmodule

// ----- rtl/aavr_matrix.sv -----
// three-stage build of the rotation matrix from cos, sin and the axis
// uses aavr_pkg
module aavr_matrix #(
  parameter int VEC_WIDTH = 18
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        feed_valid,
  output logic                        feed_ready,
  input  aavr_pkg::cs_t               cos_q,
  input  aavr_pkg::cs_t               sin_q,
  input  logic signed [VEC_WIDTH-1:0] vec_in [3],
  input  aavr_pkg::axis_t             axis_in [3],
  output logic                        res_valid,
  input  logic                        res_ready,
  output aavr_pkg::mat_t              mat [9],
  output logic signed [VEC_WIDTH-1:0] vec_out [3]
);

  localparam int N = 3;
  localparam int P1_W = aavr_pkg::CS_W + aavr_pkg::AXIS_W;
  localparam int P2_W = aavr_pkg::BN_W + aavr_pkg::AXIS_W;
  localparam logic signed [P1_W-1:0] RND1 = P1_W'(1) <<< (aavr_pkg::AXIS_FRAC - 1);
  localparam logic signed [P2_W-1:0] RND2 = P2_W'(1) <<< (aavr_pkg::AXIS_FRAC - 1);
  localparam aavr_pkg::m_t RND3 = aavr_pkg::M_W'(1) <<< (aavr_pkg::MAT_DROP - 1);

  logic [N-1:0] vld;
  logic [N:0]   adv;

  aavr_pkg::cs_t b_q;
  logic signed [P1_W-1:0] pb [3];
  logic signed [P1_W-1:0] ps [3];

  aavr_pkg::bn_t               bn [3];
  aavr_pkg::bn_t               sn [3];
  aavr_pkg::cs_t               c_a;
  aavr_pkg::axis_t             n_a [3];
  logic signed [VEC_WIDTH-1:0] v_a [3];

  logic signed [P2_W-1:0] pm [9];
  aavr_pkg::m_t           madd [9];
  aavr_pkg::m_t           m_b [9];
  logic signed [VEC_WIDTH-1:0] v_b [3];

  aavr_pkg::m_t                  mr [9];
  logic signed [aavr_pkg::M_W-aavr_pkg::MAT_DROP-1:0] ms [9];

  always_comb begin
    adv[N] = res_ready;
    for (int k = N - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign feed_ready = adv[0];
  assign res_valid  = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= feed_valid;
      end
      for (int k = 1; k < N; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // b*n and s*n, rounded back to q30
  always_comb begin
    b_q = aavr_pkg::ONE_Q30 - cos_q;
    for (int i = 0; i < 3; i++) begin
      pb[i] = b_q * axis_in[i] + RND1;
      ps[i] = sin_q * axis_in[i] + RND1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < 3; i++) begin
        bn[i] <= pb[i][P1_W-1:aavr_pkg::AXIS_FRAC];
        sn[i] <= ps[i][P1_W-1:aavr_pkg::AXIS_FRAC];
      end
      c_a <= cos_q;
      n_a <= axis_in;
      v_a <= vec_in;
    end
  end

  // outer product plus cos on the diagonal and the cross-product terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pm[3*i+j] = bn[i] * n_a[j] + RND2;
      end
    end
    madd[0] = aavr_pkg::M_W'(c_a);
    madd[4] = aavr_pkg::M_W'(c_a);
    madd[8] = aavr_pkg::M_W'(c_a);
    madd[1] = -aavr_pkg::M_W'(sn[2]);
    madd[3] = aavr_pkg::M_W'(sn[2]);
    madd[2] = aavr_pkg::M_W'(sn[1]);
    madd[6] = -aavr_pkg::M_W'(sn[1]);
    madd[5] = -aavr_pkg::M_W'(sn[0]);
    madd[7] = aavr_pkg::M_W'(sn[0]);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int e = 0; e < 9; e++) begin
        m_b[e] <= aavr_pkg::M_W'($signed(pm[e][P2_W-1:aavr_pkg::AXIS_FRAC])) + madd[e];
      end
      v_b <= v_a;
    end
  end

  // round to q24 and clamp
  always_comb begin
    for (int e = 0; e < 9; e++) begin
      mr[e] = m_b[e] + RND3;
      ms[e] = mr[e][aavr_pkg::M_W-1:aavr_pkg::MAT_DROP];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int e = 0; e < 9; e++) begin
        priority if (ms[e] > $signed(aavr_pkg::MAT_HI)) begin
          mat[e] <= aavr_pkg::MAT_HI;
        end else if (ms[e] < $signed(aavr_pkg::MAT_LO)) begin
          mat[e] <= aavr_pkg::MAT_LO;
        end else begin
          mat[e] <= aavr_pkg::MAT_W'(ms[e]);
        end
      end
      vec_out <= v_b;
    end
  end

endmodule

// ----- rtl/aavr_apply.sv -----
// matrix times vector in two stages: products, then sum, round and saturate
// uses aavr_pkg
module aavr_apply #(
  parameter int VEC_WIDTH = 18
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        feed_valid,
  output logic                        feed_ready,
  input  aavr_pkg::mat_t              mat [9],
  input  logic signed [VEC_WIDTH-1:0] vec_in [3],
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic signed [VEC_WIDTH-1:0] rot [3]
);

  localparam int N    = 2;
  localparam int PR_W = aavr_pkg::MAT_W + VEC_WIDTH;
  localparam int AC_W = PR_W + 2;
  localparam int R_W  = AC_W - aavr_pkg::MAT_FRAC;
  localparam logic signed [AC_W-1:0] RND = AC_W'(1) <<< (aavr_pkg::MAT_FRAC - 1);
  localparam longint HI_L = (longint'(1) <<< (VEC_WIDTH - 1)) - 1;
  localparam logic signed [R_W-1:0] R_HI = R_W'(HI_L);
  localparam logic signed [R_W-1:0] R_LO = R_W'(-HI_L - 1);

  logic [N-1:0] vld;
  logic [N:0]   adv;

  logic signed [PR_W-1:0] pr [9];
  logic signed [AC_W-1:0] acc [3];
  logic signed [R_W-1:0]  rs [3];

  always_comb begin
    adv[N] = res_ready;
    for (int k = N - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign feed_ready = adv[0];
  assign res_valid  = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= feed_valid;
      end
      if (adv[1]) begin
        vld[1] <= vld[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr[3*i+j] <= mat[3*i+j] * vec_in[j];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = AC_W'(pr[3*i]) + AC_W'(pr[3*i+1]) + AC_W'(pr[3*i+2]) + RND;
      rs[i]  = acc[i][AC_W-1:aavr_pkg::MAT_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        priority if (rs[i] > R_HI) begin
          rot[i] <= VEC_WIDTH'(R_HI);
        end else if (rs[i] < R_LO) begin
          rot[i] <= VEC_WIDTH'(R_LO);
        end else begin
          rot[i] <= VEC_WIDTH'(rs[i]);
        end
      end
    end
  end

endmodule

// ----- rtl/axis_angle_vector_rotation_unit.sv -----
// top level of the axis-angle (rodrigues) vector rotation unit
// uses aavr_pkg, aavr_in_if, aavr_out_if, aavr_cordic, aavr_matrix, aavr_apply
//
//   port     dir   word contents
//   items    in    vec_x/y/z, axis_x/y/z, angle
//   results  out   rot_x/y/z
//
// one word accepted per cycle while no stall on results holds the pipeline
// (cordic: one stage per iteration plus entry and quadrant stages,
// matrix: three stages, matrix-vector product: two stages)
// every stage has its own valid bit and loads when empty or when the next
// stage moves, so a stall on results fills bubbles before items stops
// synchronous reset clears the valid bits only
module axis_angle_vector_rotation_unit #(
  parameter int VEC_WIDTH     = 18,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input logic          clk,
  input logic          rst,
  aavr_in_if.sink      items,
  aavr_out_if.source   results
);

  logic signed [VEC_WIDTH-1:0] vec_in [3];
  aavr_pkg::axis_t             axis_in [3];

  logic                        c_valid;
  logic                        c_ready;
  aavr_pkg::cs_t               cos_q;
  aavr_pkg::cs_t               sin_q;
  logic signed [VEC_WIDTH-1:0] c_vec [3];
  aavr_pkg::axis_t             c_axis [3];

  logic                        m_valid;
  logic                        m_ready;
  aavr_pkg::mat_t              mat [9];
  logic signed [VEC_WIDTH-1:0] m_vec [3];

  logic signed [VEC_WIDTH-1:0] rot [3];

  assign vec_in[0]  = items.vec_x;
  assign vec_in[1]  = items.vec_y;
  assign vec_in[2]  = items.vec_z;
  assign axis_in[0] = items.axis_x;
  assign axis_in[1] = items.axis_y;
  assign axis_in[2] = items.axis_z;

  aavr_cordic #(
    .VEC_WIDTH     (VEC_WIDTH),
    .ANGLE_BITS    (ANGLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk        (clk),
    .rst        (rst),
    .feed_valid (items.valid),
    .feed_ready (items.ready),
    .angle      (items.angle),
    .vec_in     (vec_in),
    .axis_in    (axis_in),
    .res_valid  (c_valid),
    .res_ready  (c_ready),
    .cos_q      (cos_q),
    .sin_q      (sin_q),
    .vec_out    (c_vec),
    .axis_out   (c_axis)
  );

  aavr_matrix #(
    .VEC_WIDTH (VEC_WIDTH)
  ) u_matrix (
    .clk        (clk),
    .rst        (rst),
    .feed_valid (c_valid),
    .feed_ready (c_ready),
    .cos_q      (cos_q),
    .sin_q      (sin_q),
    .vec_in     (c_vec),
    .axis_in    (c_axis),
    .res_valid  (m_valid),
    .res_ready  (m_ready),
    .mat        (mat),
    .vec_out    (m_vec)
  );

  aavr_apply #(
    .VEC_WIDTH (VEC_WIDTH)
  ) u_apply (
    .clk        (clk),
    .rst        (rst),
    .feed_valid (m_valid),
    .feed_ready (m_ready),
    .mat        (mat),
    .vec_in     (m_vec),
    .res_valid  (results.valid),
    .res_ready  (results.ready),
    .rot        (rot)
  );

  assign results.rot_x = rot[0];
  assign results.rot_y = rot[1];
  assign results.rot_z = rot[2];

endmodule

// ----- tb/axis_angle_vector_rotation_unit_test.sv -----
// testbench for the axis-angle vector rotation unit: random and directed words,
// results checked against a bit-exact rodrigues rotation predictor
// uses aavr_pkg, aavr_in_if, aavr_out_if, axis_angle_vector_rotation_unit
module axis_angle_vector_rotation_unit_test;

  localparam int VW = 18;
  localparam int AB = 16;
  localparam int STAGES = 16;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
  } vec3_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int cycles = 0;
  int errors = 0;
  int sent = 0;
  int got = 0;
  bit idle_on = 1'b1;
  bit hold_off = 1'b0;
  vec3_t rotated_q[$];

  aavr_in_if #(.VEC_WIDTH(VW), .ANGLE_BITS(AB)) items();
  aavr_out_if #(.VEC_WIDTH(VW)) results();

  axis_angle_vector_rotation_unit #(
    .VEC_WIDTH(VW), .ANGLE_BITS(AB), .CORDIC_STAGES(STAGES)
  ) u_dut (
    .clk(clk), .rst(rst), .items(items.sink), .results(results.source)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic vec3_t rodrigues(vec3_t v, aavr_pkg::axis_t ax, aavr_pkg::axis_t ay,
                                      aavr_pkg::axis_t az, logic [AB-1:0] ang);
    logic [31:0] a, d;
    logic [1:0] q;
    longint z, x, y, dx, dy, c, s, b, acc, r;
    longint n[3], vv[3], bn[3], sn[3], m[3][3];
    vec3_t res;
    a = {ang, {(32 - AB){1'b0}}};
    q = 2'((a + 32'h20000000) >> 30);
    d = a - {q, 30'd0};
    z = longint'(signed'(d));
    x = aavr_pkg::GAIN_Q30;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(aavr_pkg::ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(aavr_pkg::ATAN_TURNS[i]);
      end
    end
    case (q)
      aavr_pkg::QUAD_0: begin c = x; s = y; end
      aavr_pkg::QUAD_1: begin c = -y; s = x; end
      aavr_pkg::QUAD_2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    b = (longint'(1) <<< 30) - c;
    n[0] = ax; n[1] = ay; n[2] = az;
    vv[0] = v.x; vv[1] = v.y; vv[2] = v.z;
    for (int i = 0; i < 3; i++) begin
      bn[i] = rnd_shift(b * n[i], aavr_pkg::AXIS_FRAC);
      sn[i] = rnd_shift(s * n[i], aavr_pkg::AXIS_FRAC);
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i][j] = rnd_shift(bn[i] * n[j], aavr_pkg::AXIS_FRAC);
    m[0][0] += c; m[1][1] += c; m[2][2] += c;
    m[0][1] -= sn[2]; m[1][0] += sn[2];
    m[0][2] += sn[1]; m[2][0] -= sn[1];
    m[1][2] -= sn[0]; m[2][1] += sn[0];
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++)
        acc += clampl(rnd_shift(m[i][j], aavr_pkg::MAT_DROP), -(longint'(1) <<< 30),
                      longint'(1) <<< 30) * vv[j];
      r = clampl(rnd_shift(acc, aavr_pkg::MAT_FRAC), -(longint'(1) <<< (VW - 1)),
                 (longint'(1) <<< (VW - 1)) - 1);
      if (i == 0) res.x = VW'(r);
      else if (i == 1) res.y = VW'(r);
      else res.z = VW'(r);
    end
    return res;
  endfunction

  // receiver: random stalls while idle_on is set, else always ready, or a long hold-off when asked
  initial begin
    results.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) results.ready <= 1'b0;
      else results.ready <= idle_on ? ($urandom_range(99) >= 37) : 1'b1;
    end
  end

  always @(posedge clk) begin
    vec3_t exp_v;
    if (!rst && results.valid && results.ready) begin
      got <= got + 1;
      if (rotated_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        exp_v = rotated_q.pop_front();
        if (results.rot_x !== exp_v.x) begin
          $error("rot_x exp %0d got %0d", exp_v.x, results.rot_x); errors++;
        end
        if (results.rot_y !== exp_v.y) begin
          $error("rot_y exp %0d got %0d", exp_v.y, results.rot_y); errors++;
        end
        if (results.rot_z !== exp_v.z) begin
          $error("rot_z exp %0d got %0d", exp_v.z, results.rot_z); errors++;
        end
      end
    end
  end

  task automatic send_word(vec3_t v, aavr_pkg::axis_t ax, aavr_pkg::axis_t ay,
                           aavr_pkg::axis_t az, logic [AB-1:0] ang);
    while (idle_on && $urandom_range(99) < 37) begin
      items.valid <= 1'b0;
      @(posedge clk);
    end
    items.valid <= 1'b1;
    items.vec_x <= v.x; items.vec_y <= v.y; items.vec_z <= v.z;
    items.axis_x <= ax; items.axis_y <= ay; items.axis_z <= az;
    items.angle <= ang;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
    rotated_q.push_back(rodrigues(v, ax, ay, az, ang));
    sent++;
  endtask

  task automatic drain;
    items.valid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (STAGES + 12) @(posedge clk);
  endtask

  function automatic vec3_t rand_vec(bit full);
    vec3_t v;
    v.x = full ? VW'($urandom) : VW'($urandom_range(16383) - 8192);
    v.y = full ? VW'($urandom) : VW'($urandom_range(16383) - 8192);
    v.z = full ? VW'($urandom) : VW'($urandom_range(16383) - 8192);
    return v;
  endfunction

  task automatic test_directed;
    vec3_t vmax, vmin, vone;
    logic [AB-1:0] angs[8];
    vmax = '{131071, 131071, 131071};
    vmin = '{-131072, -131072, -131072};
    vone = '{4096, -4096, 2048};
    angs = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'hE000,
             16'hFFFF, 16'h1FFF};
    foreach (angs[k]) send_word(vone, 16384, 0, 0, angs[k]);
    send_word(vmax, 0, 0, 16384, 16'h1555);
    send_word(vmin, 0, -16384, 0, 16'h7000);
    send_word(vmax, 9459, 9459, 9459, 16'h8000);
    send_word(vmin, -16384, -16384, -16384, 16'h8000);
    send_word(vmax, 16384, 16384, 16384, 16'h4000);
    send_word(vmin, -16384, 16384, -16384, 16'hBFFF);
    send_word(vmax, -32768, 32767, -32768, 16'h6000);
    send_word(vone, 32767, 32767, 32767, 16'h0001);
    send_word(vmax, 0, 0, 0, 16'h0000);
    send_word(vmin, 0, 0, 0, 16'h8000);
    drain();
  endtask

  task automatic test_random(int count);
    aavr_pkg::axis_t ax, ay, az;
    for (int k = 0; k < count; k++) begin
      idle_on = (k % 600) < 450;
      // mostly unit-ish axes, some raw 16-bit noise
      if ($urandom_range(9) < 7) begin
        ax = aavr_pkg::axis_t'($urandom_range(32768) - 16384);
        ay = aavr_pkg::axis_t'($urandom_range(32768) - 16384);
        az = aavr_pkg::axis_t'($urandom_range(32768) - 16384);
      end else begin
        ax = aavr_pkg::axis_t'($urandom);
        ay = aavr_pkg::axis_t'($urandom);
        az = aavr_pkg::axis_t'($urandom);
      end
      send_word(rand_vec($urandom_range(1)), ax, ay, az, AB'($urandom));
    end
    drain();
  endtask

  task automatic test_backpressure;
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int k = 0; k < 60; k++)
          send_word(rand_vec(1), aavr_pkg::axis_t'($urandom), 0, 16384, AB'($urandom));
      end
    join
    drain();
  endtask

  initial begin
    items.valid = 1'b0;
    items.vec_x = '0; items.vec_y = '0; items.vec_z = '0;
    items.axis_x = '0; items.axis_y = '0; items.axis_z = '0;
    items.angle = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(1900);
    drain();
    $display("covered %0d words, %0d results: angle and axis extremes, overflow,",
             sent, got);
    $display("non-unit axes, a long result stall and random gaps");
    if (errors == 0 && rotated_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// ----- axis_angle_vector_rotation_unit.f -----
rtl/aavr_pkg.sv
rtl/aavr_in_if.sv
rtl/aavr_out_if.sv
rtl/aavr_cordic.sv
rtl/aavr_matrix.sv
rtl/aavr_apply.sv
rtl/axis_angle_vector_rotation_unit.sv
tb/axis_angle_vector_rotation_unit_test.sv
